// ===== src/ialu_pkg.sv =====
// shared types, opcodes and helpers for the 64-bit integer alu
package ialu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned OpW = 5;
  // one radix-2 divide step or one shift-add multiply step per cell
  localparam int unsigned NumCells = 64;
  localparam int unsigned ShW = 6;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_NOT = 5'd8, OP_ASR = 5'd9,
    OP_LSL = 5'd10, OP_LSR = 5'd11, OP_BIT = 5'd12, OP_EQ = 5'd13, OP_GE = 5'd14,
    OP_LT = 5'd15, OP_ABS = 5'd16, OP_POP = 5'd17
  } opcode_t;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             divide_error;
  } out_item_t;

  // payload carried from cell to cell
  typedef struct packed {
    logic [DataW-1:0] rem;      // partial remainder, or product accumulator
    logic [DataW-1:0] quo;      // dividend or multiplier bits shifting out
    logic [DataW-1:0] dsr;      // divisor magnitude, or multiplicand
    logic [DataW-1:0] early;    // result of an opcode finished in the front stage
    logic             is_div;
    logic             is_mod;
    logic             is_mul;
    logic             neg_q;
    logic             neg_r;
    logic             err;
  } cell_data_t;

  // masks for the popcount adder tree
  localparam logic [DataW-1:0] PopMask1 = 64'h5555_5555_5555_5555;
  localparam logic [DataW-1:0] PopMask2 = 64'h3333_3333_3333_3333;
  localparam logic [DataW-1:0] PopMask4 = 64'h0F0F_0F0F_0F0F_0F0F;
  localparam logic [DataW-1:0] PopMask8 = 64'h00FF_00FF_00FF_00FF;
  localparam logic [DataW-1:0] PopMask16 = 64'h0000_FFFF_0000_FFFF;
  localparam logic [DataW-1:0] PopMask32 = 64'h0000_0000_FFFF_FFFF;

  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] x);
    magnitude = x[DataW-1] ? (~x + 1'b1) : x;
  endfunction

  // pairwise field sums, six levels
  function automatic logic [DataW-1:0] popcount(input logic [DataW-1:0] x);
    logic [DataW-1:0] s;
    s = (x & PopMask1) + ((x >> 1) & PopMask1);
    s = (s & PopMask2) + ((s >> 2) & PopMask2);
    s = (s & PopMask4) + ((s >> 4) & PopMask4);
    s = (s & PopMask8) + ((s >> 8) & PopMask8);
    s = (s & PopMask16) + ((s >> 16) & PopMask16);
    s = (s & PopMask32) + ((s >> 32) & PopMask32);
    popcount = s;
  endfunction

endpackage

// ===== src/integer_alu_64_unit.sv =====
// top level of the pipelined 64-bit integer alu
// Fully pipelined: one item per cycle while no stall holds it; a front stage, a row of
// 64 cells each giving one quotient bit or folding in one multiplier bit, and the
// output register. All opcodes take the same path so results leave in order.
// The whole pipeline advances while the output register is empty or being taken;
// stall on the result side freezes every stage and raises in_stall.
module integer_alu_64_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ialu_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ialu_pkg::out_item_t   out_data
);

  logic                 adv;
  logic                 v [ialu_pkg::NumCells+1];
  ialu_pkg::cell_data_t d [ialu_pkg::NumCells+1];
  ialu_pkg::cell_data_t last;
  ialu_pkg::out_item_t  res;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ialu_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid), .in_item(in_data),
    .out_valid(v[0]), .out_data(d[0])
  );

  // row of divide and multiply cells
  for (genvar g = 0; g < ialu_pkg::NumCells; g++) begin : g_cell
    ialu_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv), .in_valid(v[g]), .in_data(d[g]),
      .out_valid(v[g+1]), .out_data(d[g+1])
    );
  end

  // sign fix-up and result select
  assign last = d[ialu_pkg::NumCells];
  always_comb begin
    res.divide_error = last.err;
    if (last.is_div) begin
      res.result = last.neg_q ? (~last.quo + 1'b1) : last.quo;
    end else if (last.is_mod) begin
      res.result = last.neg_r ? (~last.rem + 1'b1) : last.rem;
    end else if (last.is_mul) begin
      res.result = last.rem;
    end else if (last.err) begin
      res.result = '0;
    end else begin
      res.result = last.early;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[ialu_pkg::NumCells];
    end
    if (adv) begin
      out_data <= res;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // input is refused exactly when the output is blocked
  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("backpressure mismatch");
  // error flag only with zero result
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |-> out_data.result == '0)
    else $error("divide error with nonzero result");

endmodule

// ===== src/ialu_front.sv =====
// first stage: decodes the opcode, computes the operations other than divide and multiply, seeds divide and multiply
module ialu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  ialu_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ialu_pkg::cell_data_t out_data
);

  logic [ialu_pkg::DataW-1:0] a, b, ma, mb, r;
  logic [ialu_pkg::ShW-1:0]   sh;
  logic                       slt, dv, md, ml, zero;
  ialu_pkg::cell_data_t       d_next;

  assign a  = in_item.operand_a;
  assign b  = in_item.operand_b;
  assign sh = b[ialu_pkg::ShW-1:0];
  assign ma = ialu_pkg::magnitude(a);
  assign mb = ialu_pkg::magnitude(b);
  assign slt = $signed(a) < $signed(b);
  assign dv = in_item.opcode == ialu_pkg::OP_DIV;
  assign md = in_item.opcode == ialu_pkg::OP_MOD;
  assign ml = in_item.opcode == ialu_pkg::OP_MUL;
  assign zero = b == '0;

  // operations finished in this stage; divide and multiply are built in the cell row
  always_comb begin
    r = '0;
    case (in_item.opcode)
      ialu_pkg::OP_ADD: r = a + b;
      ialu_pkg::OP_SUB: r = a - b;
      ialu_pkg::OP_AND: r = a & b;
      ialu_pkg::OP_OR:  r = a | b;
      ialu_pkg::OP_XOR: r = a ^ b;
      ialu_pkg::OP_NOT: r = ~a;
      ialu_pkg::OP_ASR: r = $signed(a) >>> sh;
      ialu_pkg::OP_LSL: r = a << sh;
      ialu_pkg::OP_LSR: r = a >> sh;
      ialu_pkg::OP_BIT: r = {{(ialu_pkg::DataW-1){1'b0}}, a[sh]};
      ialu_pkg::OP_EQ:  r = {{(ialu_pkg::DataW-1){1'b0}}, a == b};
      ialu_pkg::OP_GE:  r = {{(ialu_pkg::DataW-1){1'b0}}, !slt};
      ialu_pkg::OP_LT:  r = {{(ialu_pkg::DataW-1){1'b0}}, slt};
      ialu_pkg::OP_ABS: r = ma;
      ialu_pkg::OP_POP: r = ialu_pkg::popcount(a);
      default:          r = '0;
    endcase
  end

  // seed of the cell row: multiplier bits msb first for multiply
  always_comb begin
    d_next.rem    = '0;
    d_next.quo    = ml ? b : ma;
    d_next.dsr    = ml ? a : mb;
    d_next.early  = r;
    d_next.is_div = dv && !zero;
    d_next.is_mod = md && !zero;
    d_next.is_mul = ml;
    d_next.neg_q  = a[ialu_pkg::DataW-1] ^ b[ialu_pkg::DataW-1];
    d_next.neg_r  = a[ialu_pkg::DataW-1];
    d_next.err    = (dv || md) && zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= d_next;
    end
  end

endmodule

// ===== src/ialu_cell.sv =====
// one restoring-divide or shift-add multiply step; other operations pass through unchanged
module ialu_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  ialu_pkg::cell_data_t in_data,
  output logic                 out_valid,
  output ialu_pkg::cell_data_t out_data
);

  logic [ialu_pkg::DataW:0]   trial;
  logic [ialu_pkg::DataW:0]   diff;
  ialu_pkg::cell_data_t       d_next;

  // shift in the next dividend bit and try a subtract
  assign trial = {in_data.rem, in_data.quo[ialu_pkg::DataW-1]};
  assign diff  = trial - {1'b0, in_data.dsr};

  always_comb begin
    d_next = in_data;
    if (in_data.is_div || in_data.is_mod) begin
      d_next.quo = {in_data.quo[ialu_pkg::DataW-2:0], !diff[ialu_pkg::DataW]};
      d_next.rem = diff[ialu_pkg::DataW] ? trial[ialu_pkg::DataW-1:0]
                                         : diff[ialu_pkg::DataW-1:0];
    end else if (in_data.is_mul) begin
      // double the product and add the multiplicand for the next multiplier bit
      d_next.quo = {in_data.quo[ialu_pkg::DataW-2:0], 1'b0};
      d_next.rem = {in_data.rem[ialu_pkg::DataW-2:0], 1'b0}
                 + (in_data.quo[ialu_pkg::DataW-1] ? in_data.dsr : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= d_next;
    end
  end

endmodule
